@@ rtl/spvt_pkg.sv @@
// Shared constants, register indexes and sequencer states of the position and velocity tracker.
package spvt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_W         = GAIN_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  localparam int NUM_REGS = 5;
  localparam logic [2:0] REG_INIT_POS  = 3'd0;
  localparam logic [2:0] REG_INIT_VEL  = 3'd1;
  localparam logic [2:0] REG_INIT_VAR  = 3'd2;
  localparam logic [2:0] REG_PROC_NOISE = 3'd3;
  localparam logic [2:0] REG_MEAS_NOISE = 3'd4;

  localparam longint unsigned RST_INIT_VAR   = 65536;
  localparam longint unsigned RST_PROC_NOISE = 655;
  localparam longint unsigned RST_MEAS_NOISE = 65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PV_GO,
    ST_PV_RUN,
    ST_GAIN_GO,
    ST_GAIN_RUN,
    ST_RES_GO,
    ST_RES_RUN,
    ST_VEL_GO,
    ST_VEL_RUN,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_VAR_GO,
    ST_VAR_RUN,
    ST_DONE
  } state_t;

endpackage

@@ rtl/spvt_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module spvt_mul #(
  parameter int AW = 33,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [AW:0]      sum;

  always_comb begin
    sum      = {1'b0, acc_r[AW+BW-1:BW]} + (acc_r[0] ? {1'b0, a_r} : '0);
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = {{AW{1'b0}}, b};
      a_nxt    = a;
      cnt_nxt  = CW'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {sum, acc_r[BW-1:1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ rtl/spvt_div.sv @@
// Restoring divider, one quotient bit per cycle.
module spvt_div #(
  parameter int NW = 66,
  parameter int DW = 52
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial    = {rem_r, q_r[NW-1]};
    diff     = trial - {1'b0, d_r};
    ge       = trial >= {1'b0, d_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      d_nxt    = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_nxt   = {q_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/scalar_position_velocity_tracker_core.sv @@
// Top level of the fixed-point position and velocity tracker.
//
//   channel  direction  handshake                    contents
//   in_      slave      in_tvalid / in_tready        measured position, time step
//   out_     master     out_tvalid / out_tready      position, velocity, gain; flag in tuser
//   cfg_     APB slave  psel, penable, pwrite        five registers at 4*i (8*i above 32 bits)
//
// The time for one request is set by the shared serial multiplier and the shared serial
// divider used in turn; a zero time step skips one multiply and one divide.
// Reset is synchronous and restores the register defaults and the filter state.
// A new request is taken only when the sequencer is idle; a finished result waits in the
// output register while the next request is already being processed.
module scalar_position_velocity_tracker_core #(
  parameter int DATA_WIDTH = spvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = spvt_pkg::FRAC_BITS_DEF,
  parameter int CFG_DW     = (DATA_WIDTH > 32) ? 64 : 32,
  parameter int CFG_AW     = (DATA_WIDTH > 32) ? 6 : 5,
  parameter int OUT_W      = ((2 * DATA_WIDTH + spvt_pkg::GAIN_W + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // measured_position, time_step
  input  logic [2*DATA_WIDTH-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // position_estimate, velocity_estimate, gain_used, zero padding
  output logic [OUT_W-1:0]        out_tdata,
  // zero_step_flag
  output logic                    out_tuser,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_AW-1:0]       cfg_paddr,
  input  logic [CFG_DW-1:0]       cfg_pwdata,
  output logic [CFG_DW-1:0]       cfg_prdata,
  output logic                    cfg_pready
);

  import spvt_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int MA = W + 1;
  localparam int MB = (W > GAIN_W) ? W : GAIN_W;
  localparam int MW = MA + MB;
  localparam int NW = MA + GAIN_W + F;
  localparam int DW = W + 4 + GAIN_BITS;
  localparam int XW = (MW > NW) ? MW + 2 : NW + 2;
  localparam int AS = CFG_AW - 3;

  state_t state_r, state_nxt;

  logic [W-1:0]      cfg_r [NUM_REGS];
  logic [W-1:0]      pos_r, pos_nxt;
  logic [W-1:0]      vel_r, vel_nxt;
  logic [W-1:0]      var_r, var_nxt;
  logic [W-1:0]      meas_r, meas_nxt;
  logic [W-1:0]      dt_r, dt_nxt;
  logic [W-1:0]      varp_r, varp_nxt;
  logic [W:0]        den_r, den_nxt;
  logic [W-1:0]      pp_r, pp_nxt;
  logic [GAIN_W-1:0] g_r, g_nxt;
  logic [W-1:0]      pn_r, pn_nxt;
  logic [W-1:0]      vn_r, vn_nxt;
  logic [W-1:0]      varn_r, varn_nxt;
  logic              flag_r, flag_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [W-1:0]      out_pos_r, out_pos_nxt;
  logic [W-1:0]      out_vel_r, out_vel_nxt;
  logic [GAIN_W-1:0] out_g_r, out_g_nxt;
  logic              out_flag_r, out_flag_nxt;

  logic              in_acc;
  logic              out_load;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  logic              mul_start, mul_done;
  logic [MA-1:0]     mul_a;
  logic [MB-1:0]     mul_b;
  logic [MW-1:0]     mul_prod;
  logic              div_start, div_done;
  logic [NW-1:0]     div_num;
  logic [DW-1:0]     div_den;
  logic [NW-1:0]     div_quo;

  logic [W:0]        s_var;
  logic [W:0]        vel_x, res_x, r2_x;
  logic [W:0]        vel_mag, res_mag, r2_mag;
  logic [W+3:0]      dt10;
  logic [XW-1:0]     sh, sum;

  function automatic logic [W-1:0] sat_fn(input logic [XW-1:0] v);
    logic [XW-W:0] top;
    top = v[XW-1:W-1];
    if ((&top) || !(|top)) begin
      sat_fn = v[W-1:0];
    end else if (v[XW-1]) begin
      sat_fn = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_fn = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:AS];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx < 3'(NUM_REGS)) ? CFG_DW'(cfg_r[cfg_idx]) : '0;

  assign vel_x   = (MA)'($signed(vel_r));
  assign res_x   = (MA)'($signed(meas_r)) - (MA)'($signed(pp_r));
  assign r2_x    = (MA)'($signed(meas_r)) - (MA)'($signed(pn_r));
  assign vel_mag = vel_x[W] ? -vel_x : vel_x;
  assign res_mag = res_x[W] ? -res_x : res_x;
  assign r2_mag  = r2_x[W] ? -r2_x : r2_x;
  assign dt10    = {1'b0, dt_r, 3'b000} + {3'b000, dt_r, 1'b0};
  assign s_var   = {1'b0, var_r} + {1'b0, cfg_r[REG_PROC_NOISE]};

  spvt_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  spvt_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_PV_GO;
      ST_PV_GO:    state_nxt = ST_PV_RUN;
      ST_PV_RUN:   if (mul_done) state_nxt = ST_GAIN_GO;
      ST_GAIN_GO:  state_nxt = ST_GAIN_RUN;
      ST_GAIN_RUN: if (div_done) state_nxt = ST_RES_GO;
      ST_RES_GO:   state_nxt = ST_RES_RUN;
      ST_RES_RUN: begin
        if (mul_done) state_nxt = (dt_r == '0) ? ST_VAR_GO : ST_VEL_GO;
      end
      ST_VEL_GO:   state_nxt = ST_VEL_RUN;
      ST_VEL_RUN:  if (mul_done) state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_RUN;
      ST_DIV_RUN:  if (div_done) state_nxt = ST_VAR_GO;
      ST_VAR_GO:   state_nxt = ST_VAR_RUN;
      ST_VAR_RUN:  if (mul_done) state_nxt = ST_DONE;
      ST_DONE:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = vel_mag;
    mul_b     = MB'(dt_r);
    div_num   = NW'({varp_r, {GAIN_BITS{1'b0}}});
    div_den   = DW'(den_r);
    unique case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_PV_GO:   mul_start = 1'b1;
      ST_GAIN_GO: div_start = 1'b1;
      ST_RES_GO: begin
        mul_start = 1'b1;
        mul_a     = res_mag;
        mul_b     = MB'(g_r);
      end
      ST_VEL_GO: begin
        mul_start = 1'b1;
        mul_a     = r2_mag;
        mul_b     = MB'(g_r);
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        div_num   = {mul_prod[MA+GAIN_W-1:0], {F{1'b0}}};
        div_den   = {dt10, {GAIN_BITS{1'b0}}};
      end
      ST_VAR_GO: begin
        mul_start = 1'b1;
        mul_a     = {1'b0, varp_r};
        mul_b     = MB'(GAIN_ONE - g_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    var_nxt       = var_r;
    meas_nxt      = meas_r;
    dt_nxt        = dt_r;
    varp_nxt      = varp_r;
    den_nxt       = den_r;
    pp_nxt        = pp_r;
    g_nxt         = g_r;
    pn_nxt        = pn_r;
    vn_nxt        = vn_r;
    varn_nxt      = varn_r;
    flag_nxt      = flag_r;
    out_pos_nxt   = out_pos_r;
    out_vel_nxt   = out_vel_r;
    out_g_nxt     = out_g_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sh            = '0;
    sum           = '0;

    if (in_acc) begin
      meas_nxt = in_tdata[W-1:0];
      dt_nxt   = in_tdata[2*W-1:W];
      varp_nxt = s_var[W] ? {W{1'b1}} : s_var[W-1:0];
    end

    if (state_r == ST_PV_RUN && mul_done) begin
      sh      = XW'(mul_prod[MW-1:F]);
      sum     = XW'($signed(pos_r)) + (vel_x[W] ? {XW{1'b0}} - sh : sh);
      pp_nxt  = sat_fn(sum);
      den_nxt = {1'b0, varp_r} + {1'b0, cfg_r[REG_MEAS_NOISE]};
    end

    if (state_r == ST_GAIN_RUN && div_done) begin
      g_nxt = (den_r == '0) ? '0 : div_quo[GAIN_W-1:0];
    end

    if (state_r == ST_RES_RUN && mul_done) begin
      sh       = XW'(mul_prod[MW-1:GAIN_BITS]);
      sum      = XW'($signed(pp_r)) + (res_x[W] ? {XW{1'b0}} - sh : sh);
      pn_nxt   = sat_fn(sum);
      flag_nxt = (dt_r == '0);
      vn_nxt   = vel_r;
    end

    if (state_r == ST_DIV_RUN && div_done) begin
      sh     = XW'(div_quo);
      sum    = XW'($signed(vel_r)) + (r2_x[W] ? {XW{1'b0}} - sh : sh);
      vn_nxt = sat_fn(sum);
    end

    if (state_r == ST_VAR_RUN && mul_done) begin
      varn_nxt = mul_prod[GAIN_BITS+W-1:GAIN_BITS];
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = pn_r;
      out_vel_nxt   = vn_r;
      out_g_nxt     = g_r;
      out_flag_nxt  = flag_r;
      pos_nxt       = pn_r;
      vel_nxt       = vn_r;
      var_nxt       = varn_r;
    end

    if (cfg_wr && cfg_idx < 3'(NUM_REGS)) begin
      pos_nxt = (cfg_idx == REG_INIT_POS) ? cfg_pwdata[W-1:0] : cfg_r[REG_INIT_POS];
      vel_nxt = (cfg_idx == REG_INIT_VEL) ? cfg_pwdata[W-1:0] : cfg_r[REG_INIT_VEL];
      var_nxt = (cfg_idx == REG_INIT_VAR) ? cfg_pwdata[W-1:0] : cfg_r[REG_INIT_VAR];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r               <= ST_IDLE;
      out_valid_r           <= 1'b0;
      cfg_r[REG_INIT_POS]   <= '0;
      cfg_r[REG_INIT_VEL]   <= '0;
      cfg_r[REG_INIT_VAR]   <= W'(RST_INIT_VAR);
      cfg_r[REG_PROC_NOISE] <= W'(RST_PROC_NOISE);
      cfg_r[REG_MEAS_NOISE] <= W'(RST_MEAS_NOISE);
      pos_r                 <= '0;
      vel_r                 <= '0;
      var_r                 <= W'(RST_INIT_VAR);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_idx < 3'(NUM_REGS)) begin
        cfg_r[cfg_idx] <= cfg_pwdata[W-1:0];
      end
      pos_r <= pos_nxt;
      vel_r <= vel_nxt;
      var_r <= var_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r     <= meas_nxt;
    dt_r       <= dt_nxt;
    varp_r     <= varp_nxt;
    den_r      <= den_nxt;
    pp_r       <= pp_nxt;
    g_r        <= g_nxt;
    pn_r       <= pn_nxt;
    vn_r       <= vn_nxt;
    varn_r     <= varn_nxt;
    flag_r     <= flag_nxt;
    out_pos_r  <= out_pos_nxt;
    out_vel_r  <= out_vel_nxt;
    out_g_r    <= out_g_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_g_r, out_vel_r, out_pos_r});
  assign out_tuser  = out_flag_r;

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_g_r <= GAIN_ONE))
    else $error("gain above one");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request taken while busy");

  a_flag_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && flag_r) |-> (dt_r == '0))
    else $error("zero step flag with nonzero step");

endmodule

@@ tb/scalar_position_velocity_tracker_core_tb.sv @@
// Self-checking testbench of the fixed-point position and velocity tracker core.
module scalar_position_velocity_tracker_core_tb;
  import spvt_pkg::*;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [16:0] gain;
    logic        flag;
  } est_t;

  typedef struct {
    int          phase;
    logic [31:0] meas;
    logic [31:0] dt;
    bit          known;
    est_t        res;
  } row_t;

  localparam logic [2:0] REG_BEYOND = 3'd5;
  localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] P_MIN = 32'h8000_0000;
  localparam logic [31:0] U_MAX = 32'hFFFF_FFFF;
  localparam logic signed [127:0] S_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] S_MIN = -128'sh8000_0000;
  localparam int RAND_PHASES = 5;
  localparam int RAND_ITEMS = 90;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // measured_position, time_step
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // position_estimate, velocity_estimate, gain_used, zero padding
  logic [87:0] out_tdata;
  // zero_step_flag
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  scalar_position_velocity_tracker_core uut (.*);

  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("FAIL scalar_position_velocity_tracker_core");
    $finish;
  end

  logic [31:0] reg_shadow [NUM_REGS];
  logic [31:0] st_pos, st_vel, st_var;
  est_t        pending_est [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_zero_steps = 0;
  int          n_cfg = 0;
  bit          no_idle = 1'b0;
  int          hold_cycles = 0;
  int          stall_left = 0;

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [127:0] sat_q(input logic signed [127:0] v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  // Signed value times an unsigned factor, shifted down by 16, truncated toward zero.
  function automatic logic signed [127:0] scale_trunc(input logic signed [127:0] s,
                                                      input logic [63:0] f);
    logic [127:0] m, p;
    m = s[127] ? -s : s;
    p = (m * {64'd0, f}) >> 16;
    return s[127] ? -$signed(p) : $signed(p);
  endfunction

  task automatic reload_track();
    st_pos = reg_shadow[REG_INIT_POS];
    st_vel = reg_shadow[REG_INIT_VEL];
    st_var = reg_shadow[REG_INIT_VAR];
  endtask

  task automatic track_step(input logic [31:0] meas_in, input logic [31:0] dt_in,
                            output est_t r);
    logic signed [127:0] pos, vel, meas, pp, pn, vn, resid, q;
    logic [127:0] var_p, den, g, mag, num, dd;
    pos = $signed(st_pos);
    vel = $signed(st_vel);
    meas = $signed(meas_in);
    pp = sat_q(pos + scale_trunc(vel, {32'd0, dt_in}));
    var_p = {96'd0, st_var} + {96'd0, reg_shadow[REG_PROC_NOISE]};
    if (var_p > 128'hFFFF_FFFF) var_p = 128'hFFFF_FFFF;
    den = var_p + {96'd0, reg_shadow[REG_MEAS_NOISE]};
    g = (den == 0) ? 128'd0 : (var_p << 16) / den;
    resid = meas - pp;
    pn = sat_q(pp + scale_trunc(resid, g[63:0]));
    if (dt_in == 0) begin
      r.flag = 1'b1;
      vn = vel;
    end else begin
      r.flag = 1'b0;
      resid = meas - pn;
      mag = resid[127] ? -resid : resid;
      num = (mag * g) << 16;
      dd = {96'd0, dt_in} * 128'd655360;
      q = $signed(num / dd);
      if (resid[127]) q = -q;
      vn = sat_q(vel + q);
    end
    st_var = 32'((var_p * (128'd65536 - g)) >> 16);
    st_pos = pn[31:0];
    st_vel = vn[31:0];
    r.pos = pn[31:0];
    r.vel = vn[31:0];
    r.gain = g[16:0];
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx < NUM_REGS) begin
      reg_shadow[idx] = val;
      reload_track();
    end
    n_cfg++;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // The last request is withdrawn first so that it is not taken a second time.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_est.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Offers one request; the valid stays high into the next request when no gap is drawn.
  task automatic send_request(input logic [31:0] meas, input logic [31:0] dt,
                              input bit known, input est_t typed);
    int gap;
    est_t e;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {dt, meas};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_step(meas, dt, e);
    pending_est.push_back(known ? typed : e);
    n_items++;
    if (dt == 0) n_zero_steps++;
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    est_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pos = out_tdata[31:0];
      got.vel = out_tdata[63:32];
      got.gain = out_tdata[80:64];
      got.flag = out_tuser;
      n_results++;
      if (pending_est.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pos=%h vel=%h gain=%h flag=%b", $time,
                 got.pos, got.vel, got.gain, got.flag);
      end else begin
        want = pending_est.pop_front();
        if (got.pos !== want.pos) begin
          errors++;
          $display("%0t: position expected %h actual %h", $time, want.pos, got.pos);
        end
        if (got.vel !== want.vel) begin
          errors++;
          $display("%0t: velocity expected %h actual %h", $time, want.vel, got.vel);
        end
        if (got.gain !== want.gain) begin
          errors++;
          $display("%0t: gain expected %h actual %h", $time, want.gain, got.gain);
        end
        if (got.flag !== want.flag) begin
          errors++;
          $display("%0t: zero step flag expected %b actual %b", $time, want.flag, got.flag);
        end
      end
    end
  end

  logic [31:0] dir_cfg [4][NUM_REGS];
  row_t        dir_rows [$];

  function automatic row_t mk_row(input int ph, input logic [31:0] m, input logic [31:0] d);
    row_t r;
    r.phase = ph;
    r.meas = m;
    r.dt = d;
    r.known = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic row_t mk_known(input int ph, input logic [31:0] m, input logic [31:0] d,
                                    input logic fl);
    row_t r;
    r = mk_row(ph, m, d);
    r.known = 1'b1;
    r.res.flag = fl;
    return r;
  endfunction

  function automatic logic [31:0] pick_cfg(input int idx);
    int r;
    r = $urandom_range(0, 99);
    case (idx)
      REG_INIT_POS, REG_INIT_VEL: begin
        if (r < 10) return P_MAX;
        if (r < 20) return P_MIN;
        if (r < 30) return $urandom;
        return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      end
      default: begin
        if (r < 12) return 32'd0;
        if (r < 22) return U_MAX;
        if (r < 30) return $urandom;
        return (idx == REG_PROC_NOISE) ? $urandom_range(0, 32'h4000)
                                       : $urandom_range(1, 32'h0010_0000);
      end
    endcase
  endfunction

  initial begin
    int cur;
    logic [31:0] m, d;
    int r;
    dir_cfg[1] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    dir_cfg[2] = '{P_MAX, P_MAX, U_MAX, U_MAX, 32'd0};
    dir_cfg[3] = '{P_MIN, P_MIN, 32'd0, 32'd0, U_MAX};
    dir_rows = '{
      mk_row(0, 32'd0, 32'd0), mk_row(0, P_MAX, 32'd1), mk_row(0, P_MIN, U_MAX),
      mk_row(0, 32'h1234_5678, 32'h0001_0000), mk_row(0, 32'd0, 32'd0),
      mk_known(1, P_MAX, 32'd0, 1'b1), mk_known(1, P_MIN, U_MAX, 1'b0),
      mk_known(1, 32'd1, 32'd1, 1'b0), mk_known(1, U_MAX, 32'h0001_0000, 1'b0),
      mk_row(2, 32'd0, 32'd1), mk_row(2, P_MIN, U_MAX), mk_row(2, P_MAX, 32'd0),
      mk_row(2, 32'd0, 32'h0001_0000), mk_row(2, U_MAX, 32'd2),
      mk_row(3, P_MAX, U_MAX), mk_row(3, P_MIN, 32'd1), mk_row(3, 32'd0, 32'd0),
      mk_row(3, 32'd1, 32'h0001_0000), mk_row(3, 32'h5555_5555, 32'hAAAA_AAAA)
    };
    reg_shadow[REG_INIT_POS] = 32'd0;
    reg_shadow[REG_INIT_VEL] = 32'd0;
    reg_shadow[REG_INIT_VAR] = 32'(RST_INIT_VAR);
    reg_shadow[REG_PROC_NOISE] = 32'(RST_PROC_NOISE);
    reg_shadow[REG_MEAS_NOISE] = 32'(RST_MEAS_NOISE);
    reload_track();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cur = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].phase != cur) begin
        wait_idle();
        cur = dir_rows[i].phase;
        for (int k = 0; k < NUM_REGS; k++) write_reg(3'(k), dir_cfg[cur][k]);
      end
      send_request(dir_rows[i].meas, dir_rows[i].dt, dir_rows[i].known, dir_rows[i].res);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      @(negedge clk);
      in_tvalid <= 1'b0;
      no_idle = (ph == 0);
      if (ph == 2) write_reg(REG_BEYOND, $urandom);
      for (int k = 0; k < NUM_REGS; k++) write_reg(3'(k), pick_cfg(k));
      if (ph == 1) hold_cycles = 1500;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70) m = st_pos + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        else if (r < 90) m = $urandom;
        else m = r[0] ? P_MAX : P_MIN;
        r = $urandom_range(0, 99);
        if (r < 10) d = 32'd0;
        else if (r < 20) d = $urandom;
        else d = $urandom_range(1, 32'h0004_0000);
        send_request(m, d, 1'b0, '0);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (pending_est.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d requests (%0d with a zero time step) and checked %0d results,",
             n_items, n_zero_steps, n_results);
    $display("over %0d register writes, extreme and random settings, %0d errors.",
             n_cfg, errors);
    if (errors == 0) begin
      $display("PASS scalar_position_velocity_tracker_core");
    end else begin
      $display("FAIL scalar_position_velocity_tracker_core");
    end
    $finish;
  end

endmodule
